// ===== design/i2c_master_bit_sequencer_top_defines.svh =====
// Assertion helpers shared by the sequencer modules.
// Each expects a clock named aclk and an active-low reset named aresetn.
`ifndef I2C_MASTER_BIT_SEQUENCER_TOP_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication
`define I2CBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define I2CBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/i2cbs_pkg.sv =====
package i2cbs_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int CFG_IDX_W     = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PHASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETUP_HOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_LIMIT  = 3'd3;

    // Register reset values
    localparam logic [7:0] RST_BIT_PHASE  = 8'd2;
    localparam logic [7:0] RST_SETUP_HOLD = 8'd5;
    localparam logic [7:0] RST_SAMPLE     = 8'd1;
    localparam logic [7:0] RST_ACK_LIMIT  = 8'd250;

    typedef enum logic [2:0] {
        ACT_TICK     = 3'd0,
        ACT_START    = 3'd1,
        ACT_STOP     = 3'd2,
        ACT_WRITE    = 3'd3,
        ACT_WAIT_ACK = 3'd4,
        ACT_READ     = 3'd5
    } action_t;

    typedef enum logic [3:0] {
        PH_IDLE, PH_START_A, PH_START_B, PH_STOP_A, PH_STOP_B,
        PH_WR_HIGH, PH_WR_LOW, PH_WA_REL, PH_WA_SETTLE, PH_WA_POLL,
        PH_RD_LOW, PH_RD_HIGH, PH_AK_LOW, PH_AK_HIGH
    } phase_t;

    typedef struct packed {
        logic [7:0] bit_phase_ticks;
        logic [7:0] setup_hold_ticks;
        logic [7:0] sample_ticks;
        logic [7:0] ack_wait_limit;
    } cfg_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_sample;
    } in_item_t;

    typedef struct packed {
        logic       rejected;
        logic       ack_missing;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive;
        logic       sda_level;
        logic       scl_level;
    } res_t;

    // A delay of zero still lasts one tick
    function automatic logic [7:0] at_least_one(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

endpackage

// ===== design/i2cbs_cfg_regs.sv =====
module i2cbs_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic [i2cbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                       cfg_data,
    output i2cbs_pkg::cfg_t                  cfg
);
    import i2cbs_pkg::*;

    cfg_t cfg_reg;

    // Write one timing register per accepted write; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bit_phase_ticks  <= RST_BIT_PHASE;
            cfg_reg.setup_hold_ticks <= RST_SETUP_HOLD;
            cfg_reg.sample_ticks     <= RST_SAMPLE;
            cfg_reg.ack_wait_limit   <= RST_ACK_LIMIT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BIT_PHASE:  cfg_reg.bit_phase_ticks  <= cfg_data;
                CFG_SETUP_HOLD: cfg_reg.setup_hold_ticks <= cfg_data;
                CFG_SAMPLE:     cfg_reg.sample_ticks     <= cfg_data;
                CFG_ACK_LIMIT:  cfg_reg.ack_wait_limit   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/i2cbs_core.sv =====
module i2cbs_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  i2cbs_pkg::in_item_t item,
    input  i2cbs_pkg::cfg_t     cfg,
    output i2cbs_pkg::res_t     res
);
    import i2cbs_pkg::*;
    `include "i2c_master_bit_sequencer_top_defines.svh"

    phase_t     phase_reg,   phase_next;
    logic [7:0] delay_reg,   delay_next;
    logic [7:0] shift_reg,   shift_next;
    logic [3:0] bit_idx_reg, bit_idx_next;
    logic [7:0] poll_reg,    poll_next;
    logic       ack_choice_reg, ack_choice_next;
    logic       scl_reg,     scl_next;
    logic       sda_reg,     sda_next;
    logic       drv_reg,     drv_next;
    logic [7:0] read_reg,    read_next;
    logic       missing_reg, missing_next;
    logic       done;
    logic       rej;
    logic       is_cmd;
    logic [3:0] bit_idx_inc;

    // One sequencer step for the item at hand
    always_comb begin
        phase_next      = phase_reg;
        delay_next      = delay_reg;
        shift_next      = shift_reg;
        bit_idx_next    = bit_idx_reg;
        poll_next       = poll_reg;
        ack_choice_next = ack_choice_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        drv_next        = drv_reg;
        read_next       = read_reg;
        missing_next    = missing_reg;
        done            = 1'b0;
        is_cmd          = (item.action >= ACT_START) && (item.action <= ACT_READ);
        rej             = is_cmd && (phase_reg != PH_IDLE);
        bit_idx_inc     = bit_idx_reg + 4'd1;

        if (is_cmd && (phase_reg == PH_IDLE)) begin
            // Start a command: set the first line levels and load the first delay
            missing_next = 1'b0;
            unique case (item.action)
                ACT_START: begin
                    drv_next   = 1'b1;
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                    phase_next = PH_START_A;
                    delay_next = at_least_one(cfg.setup_hold_ticks);
                end
                ACT_STOP: begin
                    drv_next   = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    phase_next = PH_STOP_A;
                    delay_next = at_least_one(cfg.setup_hold_ticks);
                end
                ACT_WRITE: begin
                    drv_next     = 1'b1;
                    bit_idx_next = 4'd0;
                    sda_next     = item.write_data[7];
                    shift_next   = {item.write_data[6:0], 1'b0};
                    scl_next     = 1'b1;
                    phase_next   = PH_WR_HIGH;
                    delay_next   = at_least_one(cfg.bit_phase_ticks);
                end
                ACT_WAIT_ACK: begin
                    drv_next   = 1'b0;
                    sda_next   = 1'b1;
                    phase_next = PH_WA_REL;
                    delay_next = at_least_one(cfg.sample_ticks);
                end
                default: begin
                    drv_next        = 1'b0;
                    sda_next        = 1'b1;
                    scl_next        = 1'b0;
                    shift_next      = 8'd0;
                    bit_idx_next    = 4'd0;
                    ack_choice_next = item.send_ack;
                    phase_next      = PH_RD_LOW;
                    delay_next      = at_least_one(cfg.bit_phase_ticks);
                end
            endcase
        end else if (phase_reg == PH_IDLE) begin
            // Tick while idle: hold everything
        end else if (phase_reg == PH_WA_POLL) begin
            // Poll SDA once per tick while SCL is high
            if (!item.sda_sample) begin
                scl_next = 1'b0;
                done     = 1'b1;
            end else if (poll_reg >= cfg.ack_wait_limit) begin
                missing_next = 1'b1;
                drv_next     = 1'b1;
                scl_next     = 1'b0;
                sda_next     = 1'b0;
                phase_next   = PH_STOP_A;
                delay_next   = at_least_one(cfg.setup_hold_ticks);
            end else begin
                poll_next = poll_reg + 8'd1;
            end
        end else if (delay_reg > 8'd1) begin
            delay_next = delay_reg - 8'd1;
        end else begin
            // Delay ran out: advance to the next phase
            delay_next = 8'd0;
            unique case (phase_reg)
                PH_START_A: begin
                    sda_next   = 1'b0;
                    phase_next = PH_START_B;
                    delay_next = at_least_one(cfg.setup_hold_ticks);
                end
                PH_START_B: begin
                    scl_next = 1'b0;
                    done     = 1'b1;
                end
                PH_STOP_A: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    phase_next = PH_STOP_B;
                    delay_next = at_least_one(cfg.setup_hold_ticks);
                end
                PH_WR_HIGH: begin
                    scl_next   = 1'b0;
                    phase_next = PH_WR_LOW;
                    delay_next = at_least_one(cfg.bit_phase_ticks);
                end
                PH_WR_LOW: begin
                    bit_idx_next = bit_idx_inc;
                    if (bit_idx_inc >= 4'(BITS_PER_BYTE)) begin
                        done = 1'b1;
                    end else begin
                        sda_next   = shift_reg[7];
                        shift_next = {shift_reg[6:0], 1'b0};
                        scl_next   = 1'b1;
                        phase_next = PH_WR_HIGH;
                        delay_next = at_least_one(cfg.bit_phase_ticks);
                    end
                end
                PH_WA_REL: begin
                    scl_next   = 1'b1;
                    phase_next = PH_WA_SETTLE;
                    delay_next = at_least_one(cfg.sample_ticks);
                end
                PH_WA_SETTLE: begin
                    phase_next = PH_WA_POLL;
                    poll_next  = 8'd0;
                end
                PH_RD_LOW: begin
                    scl_next     = 1'b1;
                    shift_next   = {shift_reg[6:0], item.sda_sample};
                    bit_idx_next = bit_idx_inc;
                    phase_next   = PH_RD_HIGH;
                    delay_next   = at_least_one(cfg.sample_ticks);
                end
                PH_RD_HIGH: begin
                    scl_next = 1'b0;
                    if (bit_idx_reg >= 4'(BITS_PER_BYTE)) begin
                        read_next  = shift_reg;
                        drv_next   = 1'b1;
                        sda_next   = !ack_choice_reg;
                        phase_next = PH_AK_LOW;
                        delay_next = at_least_one(cfg.bit_phase_ticks);
                    end else begin
                        phase_next = PH_RD_LOW;
                        delay_next = at_least_one(cfg.bit_phase_ticks);
                    end
                end
                PH_AK_LOW: begin
                    scl_next   = 1'b1;
                    phase_next = PH_AK_HIGH;
                    delay_next = at_least_one(ack_choice_reg ? cfg.setup_hold_ticks
                                                             : cfg.bit_phase_ticks);
                end
                PH_AK_HIGH: begin
                    scl_next = 1'b0;
                    done     = 1'b1;
                end
                default: begin
                    done = 1'b1;
                end
            endcase
        end

        // Drop back to idle at the end of a sequence
        if (done) begin
            phase_next = PH_IDLE;
            delay_next = 8'd0;
        end
    end

    // Advance the sequencer state once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            delay_reg      <= 8'd0;
            shift_reg      <= 8'd0;
            bit_idx_reg    <= 4'd0;
            poll_reg       <= 8'd0;
            ack_choice_reg <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            drv_reg        <= 1'b1;
            read_reg       <= 8'd0;
            missing_reg    <= 1'b0;
        end else if (step_en) begin
            phase_reg      <= phase_next;
            delay_reg      <= delay_next;
            shift_reg      <= shift_next;
            bit_idx_reg    <= bit_idx_next;
            poll_reg       <= poll_next;
            ack_choice_reg <= ack_choice_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            drv_reg        <= drv_next;
            read_reg       <= read_next;
            missing_reg    <= missing_next;
        end
    end

    // Result of this step
    always_comb begin
        res.scl_level   = scl_next;
        res.sda_level   = sda_next;
        res.sda_drive   = drv_next;
        res.busy_res    = (phase_next != PH_IDLE);
        res.done_res    = done;
        res.read_data   = read_next;
        res.ack_missing = missing_next;
        res.rejected    = rej;
    end

    `I2CBS_ASSERT_NEXT(a_done_goes_idle, step_en && done, phase_reg == PH_IDLE, "done but still busy")
    `I2CBS_ASSERT_NOW(a_reject_only_busy, step_en && rej, phase_reg != PH_IDLE, "rejected while idle")
    `I2CBS_ASSERT_NEXT(a_hold_without_item, !step_en, $stable(phase_reg) && $stable(delay_reg), "state moved without an item")
    `I2CBS_ASSERT_NOW(a_done_not_busy, step_en && done, !res.busy_res, "done and busy together")

endmodule

// ===== design/i2c_master_bit_sequencer_top.sv =====
// I2C master line sequencer. Each input item is a tick or a command (start, stop, write byte,
// wait for acknowledge, read byte with ACK/NACK); every item yields exactly one result item
// carrying the SCL level, SDA level and SDA drive enable after that item, plus busy, done,
// the last read byte, the missing-acknowledge flag and a flag for commands rejected while busy.
// Delays count in ticks and are set through four timing registers on the configuration port,
// which should be written only while no sequence is running. An item passes through an input
// register, one sequencer step and an output register, and the block takes a new item every
// cycle as long as the result side keeps up.
module i2c_master_bit_sequencer_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input item stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,  // write_data[7:0], send_ack[8], sda_sample[9], zero
    input  logic [2:0]                      s_tuser,  // action[2:0]
    // Result item stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,  // scl_level[0], sda_level[1], sda_drive[2],
                                                      // busy_res[3], done_res[4], read_data[12:5],
                                                      // ack_missing[13], rejected[14], zero[15]
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [i2cbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data
);
    import i2cbs_pkg::*;
    `include "i2c_master_bit_sequencer_top_defines.svh"

    logic     in_valid_reg;
    in_item_t in_item_reg;
    logic     out_valid_reg;
    res_t     out_res_reg;
    logic     step_en;
    cfg_t     cfg;
    res_t     step_res;

    // Step when an item is held and the output slot is free or being emptied
    assign step_en   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || step_en;
    assign cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.action     <= s_tuser;
            in_item_reg.write_data <= s_tdata[7:0];
            in_item_reg.send_ack   <= s_tdata[8];
            in_item_reg.sda_sample <= s_tdata[9];
        end
    end

    i2cbs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    i2cbs_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_res_reg};

    `I2CBS_ASSERT_NOW(a_no_overwrite, out_valid_reg && !m_tready, !step_en, "pending result overwritten")
    `I2CBS_ASSERT_NEXT(a_step_fills_output, step_en, out_valid_reg, "step without a result")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import i2cbs_pkg::*;

    // Actions outside the command set; the sequencer takes them as ticks
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    // How SDA is sensed while a sequence is finished off
    localparam int SDA_RANDOM = 0;
    localparam int SDA_HIGH   = 1;
    localparam int SDA_LOW    = 2;

    localparam int LONG_HOLD_CYCLES = 80;
    localparam int PHASE_ITEMS      = 30;

    // Sequencer state plus its timing registers
    typedef struct {
        phase_t     ph;
        logic [7:0] dly;
        logic [7:0] shreg;
        logic [7:0] polls;
        logic [3:0] bidx;
        logic       ack_sel;
        logic       scl;
        logic       sda;
        logic       drv;
        logic       missing;
        logic [7:0] rd_byte;
        logic [7:0] bit_phase;
        logic [7:0] setup_hold;
        logic [7:0] sample_t;
        logic [7:0] ack_limit;
    } seq_state_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata   = '0;
    logic [2:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [15:0]          m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = '0;

    in_item_t   pend_q[$];
    res_t       line_expect_q[$];
    seq_state_t plan_st;
    seq_state_t model_st;
    in_item_t   cur_item;
    int         fail_count   = 0;
    int         result_count = 0;
    int         busy_items   = 0;
    bit         idle_en      = 1'b1;
    int         hold_req     = 0;
    int         hold_ack     = 0;
    int         src_gap      = 0;
    int         sink_hold    = 0;
    int         sink_stall   = 0;

    i2c_master_bit_sequencer_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // ---------------------------------------------------------------
    // Line sequencer prediction
    // ---------------------------------------------------------------

    function automatic seq_state_t fresh_state();
        seq_state_t st;
        st.ph         = PH_IDLE;
        st.dly        = '0;
        st.shreg      = '0;
        st.polls      = '0;
        st.bidx       = '0;
        st.ack_sel    = 1'b0;
        st.scl        = 1'b1;
        st.sda        = 1'b1;
        st.drv        = 1'b1;
        st.missing    = 1'b0;
        st.rd_byte    = '0;
        st.bit_phase  = RST_BIT_PHASE;
        st.setup_hold = RST_SETUP_HOLD;
        st.sample_t   = RST_SAMPLE;
        st.ack_limit  = RST_ACK_LIMIT;
        return st;
    endfunction

    function automatic void apply_timing(inout seq_state_t st, input logic [CFG_IDX_W-1:0] idx,
                                         input logic [7:0] val);
        case (idx)
            CFG_BIT_PHASE:  st.bit_phase  = val;
            CFG_SETUP_HOLD: st.setup_hold = val;
            CFG_SAMPLE:     st.sample_t   = val;
            CFG_ACK_LIMIT:  st.ack_limit  = val;
            default: ;
        endcase
    endfunction

    // Zero-length delays still take one tick
    function automatic logic [7:0] ticks_of(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    function automatic void enter_phase(inout seq_state_t st, input phase_t ph,
                                        input logic [7:0] ticks);
        st.ph  = ph;
        st.dly = ticks_of(ticks);
    endfunction

    // Put the next MSB on SDA with SCL high
    function automatic void shift_out_bit(inout seq_state_t st);
        st.sda   = st.shreg[7];
        st.shreg = st.shreg << 1;
        st.scl   = 1'b1;
        enter_phase(st, PH_WR_HIGH, st.bit_phase);
    endfunction

    function automatic void enter_stop(inout seq_state_t st);
        st.drv = 1'b1;
        st.scl = 1'b0;
        st.sda = 1'b0;
        enter_phase(st, PH_STOP_A, st.setup_hold);
    endfunction

    // Transition at the end of a timed phase; returns 1 when the sequence ends
    function automatic logic end_of_phase(inout seq_state_t st, input logic sda_in);
        case (st.ph)
            PH_START_A: begin
                st.sda = 1'b0;
                enter_phase(st, PH_START_B, st.setup_hold);
            end
            PH_START_B: begin
                st.scl = 1'b0;
                return 1'b1;
            end
            PH_STOP_A: begin
                st.scl = 1'b1;
                st.sda = 1'b1;
                enter_phase(st, PH_STOP_B, st.setup_hold);
            end
            PH_STOP_B: return 1'b1;
            PH_WR_HIGH: begin
                st.scl = 1'b0;
                enter_phase(st, PH_WR_LOW, st.bit_phase);
            end
            PH_WR_LOW: begin
                st.bidx = st.bidx + 4'd1;
                if (st.bidx >= 4'(BITS_PER_BYTE)) return 1'b1;
                shift_out_bit(st);
            end
            PH_WA_REL: begin
                st.scl = 1'b1;
                enter_phase(st, PH_WA_SETTLE, st.sample_t);
            end
            PH_WA_SETTLE: begin
                st.ph    = PH_WA_POLL;
                st.polls = '0;
            end
            PH_RD_LOW: begin
                st.scl   = 1'b1;
                st.shreg = {st.shreg[6:0], sda_in};
                st.bidx  = st.bidx + 4'd1;
                enter_phase(st, PH_RD_HIGH, st.sample_t);
            end
            PH_RD_HIGH: begin
                st.scl = 1'b0;
                if (st.bidx >= 4'(BITS_PER_BYTE)) begin
                    st.rd_byte = st.shreg;
                    st.drv     = 1'b1;
                    st.sda     = !st.ack_sel;
                    enter_phase(st, PH_AK_LOW, st.bit_phase);
                end else begin
                    enter_phase(st, PH_RD_LOW, st.bit_phase);
                end
            end
            PH_AK_LOW: begin
                st.scl = 1'b1;
                enter_phase(st, PH_AK_HIGH, st.ack_sel ? st.setup_hold : st.bit_phase);
            end
            PH_AK_HIGH: begin
                st.scl = 1'b0;
                return 1'b1;
            end
            default: return 1'b1;
        endcase
        return 1'b0;
    endfunction

    // One time step of a running sequence; returns 1 when it ends
    function automatic logic advance_tick(inout seq_state_t st, input logic sda_in);
        if (st.ph == PH_IDLE) return 1'b0;
        if (st.ph == PH_WA_POLL) begin
            if (!sda_in) begin
                st.scl = 1'b0;
                return 1'b1;
            end
            if (st.polls >= st.ack_limit) begin
                st.missing = 1'b1;
                enter_stop(st);
                return 1'b0;
            end
            st.polls = st.polls + 8'd1;
            return 1'b0;
        end
        if (st.dly > 8'd1) begin
            st.dly = st.dly - 8'd1;
            return 1'b0;
        end
        st.dly = '0;
        return end_of_phase(st, sda_in);
    endfunction

    function automatic res_t sequencer_step(inout seq_state_t st, input in_item_t it);
        res_t r;
        logic done;
        logic rej;
        logic is_cmd;
        done   = 1'b0;
        rej    = 1'b0;
        is_cmd = (it.action >= ACT_START) && (it.action <= ACT_READ);
        if (is_cmd && st.ph != PH_IDLE) begin
            // Busy: drop the command but keep time running
            rej  = 1'b1;
            done = advance_tick(st, it.sda_sample);
        end else if (is_cmd) begin
            st.missing = 1'b0;
            case (it.action)
                ACT_START: begin
                    st.drv = 1'b1;
                    st.sda = 1'b1;
                    st.scl = 1'b1;
                    enter_phase(st, PH_START_A, st.setup_hold);
                end
                ACT_STOP: enter_stop(st);
                ACT_WRITE: begin
                    st.drv   = 1'b1;
                    st.scl   = 1'b0;
                    st.shreg = it.write_data;
                    st.bidx  = '0;
                    shift_out_bit(st);
                end
                ACT_WAIT_ACK: begin
                    st.drv = 1'b0;
                    st.sda = 1'b1;
                    enter_phase(st, PH_WA_REL, st.sample_t);
                end
                default: begin
                    st.drv     = 1'b0;
                    st.sda     = 1'b1;
                    st.scl     = 1'b0;
                    st.shreg   = '0;
                    st.bidx    = '0;
                    st.ack_sel = it.send_ack;
                    enter_phase(st, PH_RD_LOW, st.bit_phase);
                end
            endcase
        end else begin
            done = advance_tick(st, it.sda_sample);
        end
        if (done) begin
            st.ph  = PH_IDLE;
            st.dly = '0;
        end
        r.scl_level   = st.scl;
        r.sda_level   = st.sda;
        r.sda_drive   = st.drv;
        r.busy_res    = (st.ph != PH_IDLE);
        r.done_res    = done;
        r.read_data   = st.rd_byte;
        r.ack_missing = st.missing;
        r.rejected    = rej;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Input driver
    // ---------------------------------------------------------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            // Predict the line state for the item taken at this edge
            if (s_tvalid && s_tready) begin
                line_expect_q.push_back(sequencer_step(model_st, cur_item));
            end
            // Present the next item once the current one is gone
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    cur_item = pend_q.pop_front();
                    s_tdata  <= {6'b0, cur_item.sda_sample, cur_item.send_ack,
                                 cur_item.write_data};
                    s_tuser  <= cur_item.action;
                    s_tvalid <= 1'b1;
                    if (idle_en && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 3);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor and checker
    // ---------------------------------------------------------------

    task automatic check_result(input res_t got, input logic pad);
        res_t  exp;
        string diffs;
        diffs = "";
        if (line_expect_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("result %0d arrived with nothing expected: %h",
                                           result_count, got);
            return;
        end
        exp = line_expect_q.pop_front();
        if (got.scl_level !== exp.scl_level)
            diffs = {diffs, $sformatf(" scl_level exp %0b got %0b", exp.scl_level, got.scl_level)};
        if (got.sda_level !== exp.sda_level)
            diffs = {diffs, $sformatf(" sda_level exp %0b got %0b", exp.sda_level, got.sda_level)};
        if (got.sda_drive !== exp.sda_drive)
            diffs = {diffs, $sformatf(" sda_drive exp %0b got %0b", exp.sda_drive, got.sda_drive)};
        if (got.busy_res !== exp.busy_res)
            diffs = {diffs, $sformatf(" busy_res exp %0b got %0b", exp.busy_res, got.busy_res)};
        if (got.done_res !== exp.done_res)
            diffs = {diffs, $sformatf(" done_res exp %0b got %0b", exp.done_res, got.done_res)};
        if (got.read_data !== exp.read_data)
            diffs = {diffs, $sformatf(" read_data exp %h got %h", exp.read_data, got.read_data)};
        if (got.ack_missing !== exp.ack_missing)
            diffs = {diffs, $sformatf(" ack_missing exp %0b got %0b", exp.ack_missing,
                                      got.ack_missing)};
        if (got.rejected !== exp.rejected)
            diffs = {diffs, $sformatf(" rejected exp %0b got %0b", exp.rejected, got.rejected)};
        if (pad !== 1'b0)
            diffs = {diffs, $sformatf(" pad bit exp 0 got %0b", pad)};
        if (diffs != "") begin
            fail_count++;
            if (fail_count <= 10) $display("result %0d mismatch:%s", result_count, diffs);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result(res_t'(m_tdata[14:0]), m_tdata[15]);
                result_count++;
            end
            // Pick up a request for a long hold-off
            if (hold_ack != hold_req) begin
                hold_ack  = hold_req;
                sink_hold = LONG_HOLD_CYCLES;
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end else if (sink_stall > 0) begin
                sink_stall--;
                m_tready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                sink_stall = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    task automatic push_item(input logic [2:0] act, input logic [7:0] wd, input logic ack,
                             input logic sda);
        in_item_t it;
        it.action     = act;
        it.write_data = wd;
        it.send_ack   = ack;
        it.sda_sample = sda;
        if (plan_st.ph != PH_IDLE || (act >= ACT_START && act <= ACT_READ)) busy_items++;
        void'(sequencer_step(plan_st, it));
        pend_q.push_back(it);
    endtask

    // Tick the running sequence to its end, with stray commands and spare actions mixed in when SDA is random
    task automatic finish_sequence(input int sda_mode);
        int         guard;
        logic       sda;
        logic [2:0] act;
        guard = 0;
        while (plan_st.ph != PH_IDLE && guard < 5000) begin
            case (sda_mode)
                SDA_HIGH: sda = 1'b1;
                SDA_LOW:  sda = 1'b0;
                default:  sda = ($urandom_range(0, 3) != 0);
            endcase
            act = ACT_TICK;
            if (sda_mode == SDA_RANDOM) begin
                case ($urandom_range(0, 15))
                    0, 1:    act = 3'($urandom_range(ACT_START, ACT_READ));
                    2:       act = ACT_SPARE_6;
                    3:       act = ACT_SPARE_7;
                    default: act = ACT_TICK;
                endcase
            end
            push_item(act, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sda);
            guard++;
        end
    endtask

    task automatic issue(input action_t act, input logic [7:0] wd, input logic ack,
                         input int sda_mode);
        push_item(act, wd, ack, 1'b1);
        finish_sequence(sda_mode);
    endtask

    // Hold off new items until every expected result is back
    task automatic drain_results();
        while (pend_q.size() != 0 || line_expect_q.size() != 0 || s_tvalid) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_timing(input logic [7:0] bp, input logic [7:0] sh, input logic [7:0] smp,
                              input logic [7:0] lim);
        logic [7:0]           vals [4];
        logic [CFG_IDX_W-1:0] idx  [4];
        vals = '{bp, sh, smp, lim};
        idx  = '{CFG_BIT_PHASE, CFG_SETUP_HOLD, CFG_SAMPLE, CFG_ACK_LIMIT};
        for (int k = 0; k < 4; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= vals[k];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            apply_timing(plan_st, idx[k], vals[k]);
            apply_timing(model_st, idx[k], vals[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int start_items;
        plan_st  = fresh_state();
        model_st = fresh_state();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Idle ticks and spare actions leave the lines alone; start at reset timing
        push_item(ACT_TICK, 8'h00, 1'b0, 1'b0);
        push_item(ACT_SPARE_6, 8'hFF, 1'b1, 1'b1);
        push_item(ACT_SPARE_7, 8'h5A, 1'b0, 1'b0);
        issue(ACT_START, 8'h00, 1'b0, SDA_RANDOM);
        drain_results();

        // Zero delays act as one tick; a zero poll limit fails on the first high poll
        set_timing(8'd0, 8'd0, 8'd0, 8'd0);
        issue(ACT_STOP, 8'h00, 1'b0, SDA_HIGH);
        issue(ACT_WRITE, 8'hFF, 1'b0, SDA_RANDOM);
        issue(ACT_WRITE, 8'h00, 1'b1, SDA_RANDOM);
        issue(ACT_WAIT_ACK, 8'h00, 1'b0, SDA_LOW);
        issue(ACT_WAIT_ACK, 8'hFF, 1'b1, SDA_HIGH);
        issue(ACT_READ, 8'h00, 1'b1, SDA_LOW);
        issue(ACT_READ, 8'hFF, 1'b0, SDA_HIGH);
        issue(ACT_READ, 8'hA5, 1'b1, SDA_RANDOM);
        drain_results();

        // Lower the poll limit while a wait is already past it
        set_timing(8'd1, 8'd2, 8'd1, 8'd200);
        push_item(ACT_WAIT_ACK, 8'h00, 1'b0, 1'b1);
        repeat (20) push_item(ACT_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'b1);
        drain_results();
        set_timing(8'd1, 8'd2, 8'd1, 8'd4);
        finish_sequence(SDA_HIGH);
        drain_results();

        // Longer poll limit: a wait that runs out and stops
        set_timing(8'd1, 8'd1, 8'd1, 8'd40);
        issue(ACT_WAIT_ACK, 8'h00, 1'b0, SDA_HIGH);
        drain_results();

        // Random command sequences under varied small timing
        for (int p = 0; p < 6; p++) begin
            set_timing(8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)),
                       8'($urandom_range(0, 4)),
                       ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(0, 16)));
            if (p == 5) idle_en = 1'b0;
            else idle_en = ($urandom_range(0, 3) != 0);
            if (p == 1) hold_req++;
            start_items = busy_items;
            while (busy_items - start_items < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    // Noise: any action in any state
                    push_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end else begin
                    push_item(3'($urandom_range(ACT_START, ACT_READ)),
                              8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    finish_sequence(SDA_RANDOM);
                end
            end
            drain_results();
        end

        repeat (8) @(posedge aclk);
        if (fail_count == 0 && line_expect_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
